// ===== sv/jmpe_pkg.sv =====
package jmpe_pkg;

    localparam int STEP_BITS_DEF     = 2;
    localparam int PENDING_WIDTH_DEF = 20;

    localparam int DIST_W = 16;
    localparam int GAIN_W = 12;
    localparam int PROD_W = DIST_W + GAIN_W;
    localparam int MAG_W  = PROD_W - 8;   // rounded |distance| * gain, Q4.8 fraction dropped
    localparam int PINS_W = 9;
    localparam int PAT_W  = 32;
    localparam int CFG_INDEX_W = 2;

    localparam logic [PINS_W-1:0] PIN_RESET   = 9'h16f;
    localparam logic [PAT_W-1:0]  ENC_RESET   = 32'h3c3c3c3c;
    localparam logic [PAT_W-1:0]  QUAD_RESET  = 32'hf0f0f0f0;
    localparam logic [GAIN_W-1:0] GAIN_RESET  = 12'd333;
    localparam logic [PROD_W-1:0] ROUND_HALF  = PROD_W'(128);

    // bit positions of the port pins (bit n is pin n+1)
    localparam int PIN1 = 0;
    localparam int PIN2 = 1;
    localparam int PIN3 = 2;
    localparam int PIN4 = 3;
    localparam int PIN6 = 5;
    localparam int PIN9 = 8;

    localparam logic [1:0] LEVEL_ZERO = 2'b00;
    localparam logic [1:0] LEVEL_POS1 = 2'b01;
    localparam logic [1:0] LEVEL_NEG2 = 2'b10;
    localparam logic [1:0] LEVEL_NEG1 = 2'b11;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_MOUSE_PORT = 2'd0,
        CFG_MOUSE_MODE = 2'd1,
        CFG_SPEED_GAIN = 2'd2
    } cfg_index_t;

    typedef enum logic [2:0] {
        REQ_AXIS  = 3'd0,
        REQ_FIRE  = 3'd1,
        REQ_MOVE  = 3'd2,
        REQ_LEFT  = 3'd3,
        REQ_RIGHT = 3'd4,
        REQ_TICK  = 3'd5
    } req_type_t;

    typedef struct packed {
        logic              mouse_on_second_port;
        logic              mouse_mode;
        logic [GAIN_W-1:0] speed_gain;
    } cfg_t;

    typedef struct packed {
        logic [2:0]       req_type;
        logic             port_select;
        logic             axis_select;
        logic [1:0]       level;
        logic             neg;
        logic [MAG_W-1:0] mag;
    } item_t;

endpackage

// ===== sv/jmpe_cfg_regs.sv =====
module jmpe_cfg_regs
    import jmpe_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [GAIN_W-1:0]      cfg_data,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mouse_on_second_port <= 1'b0;
            cfg_reg.mouse_mode           <= 1'b0;
            cfg_reg.speed_gain           <= GAIN_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_MOUSE_PORT: cfg_reg.mouse_on_second_port <= cfg_data[0];
                CFG_MOUSE_MODE: cfg_reg.mouse_mode           <= cfg_data[0];
                CFG_SPEED_GAIN: cfg_reg.speed_gain           <= cfg_data;
                default: ;
            endcase
        end
    end

endmodule

// ===== sv/jmpe_in_stage.sv =====
module jmpe_in_stage
    import jmpe_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  logic [2:0]        req_type,
    input  logic              port_select,
    input  logic              axis_select,
    input  logic signed [1:0] level,
    input  logic signed [DIST_W-1:0] distance,
    input  logic [GAIN_W-1:0] speed_gain,
    input  logic              take,
    output logic              item_valid,
    output item_t             item
);

    logic              valid_reg;
    item_t             item_reg;
    logic [DIST_W-1:0] dist_mag;
    logic [PROD_W-1:0] product;
    logic [PROD_W-1:0] rounded;

    // -32768 wraps to 0x8000, which is the right magnitude read unsigned
    assign dist_mag = distance[DIST_W-1] ? (~distance + DIST_W'(1)) : distance;
    assign product  = PROD_W'(dist_mag) * PROD_W'(speed_gain);
    assign rounded  = product + ROUND_HALF;

    assign req_ready  = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (req_valid && req_ready)
        begin
            valid_reg <= 1'b1;
        end
        else if (take)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            item_reg.req_type    <= req_type;
            item_reg.port_select <= port_select;
            item_reg.axis_select <= axis_select;
            item_reg.level       <= level;
            item_reg.neg         <= distance[DIST_W-1];
            item_reg.mag         <= rounded[PROD_W-1:8];
        end
    end

endmodule

// ===== sv/jmpe_pin_core.sv =====
module jmpe_pin_core
    import jmpe_pkg::*;
#(
    parameter int STEP_BITS     = STEP_BITS_DEF,
    parameter int PENDING_WIDTH = PENDING_WIDTH_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  logic              item_valid,
    input  item_t             item,
    output logic              take,
    output logic              res_valid,
    input  logic              res_ready,
    output logic [PINS_W-1:0] first_port_pins,
    output logic [PINS_W-1:0] second_port_pins
);

    localparam int PW    = PENDING_WIDTH;
    localparam int S     = STEP_BITS;
    localparam int SUM_W = ((PW > MAG_W + 1) ? PW : (MAG_W + 1)) + 1;
    localparam logic [SUM_W-1:0] SAT_MAX = {{(SUM_W - PW + 1){1'b0}}, {(PW - 1){1'b1}}};
    localparam logic [SUM_W-1:0] SAT_MIN = ~SAT_MAX;

    logic              out_valid_reg;
    logic [PINS_W-1:0] first_pins_reg;
    logic [PINS_W-1:0] second_pins_reg;
    logic [PAT_W-1:0]  h_enc_reg, h_quad_reg, v_enc_reg, v_quad_reg;
    logic [PW-1:0]     h_pend_reg, v_pend_reg;

    logic [PINS_W-1:0] pins_next [2];
    logic [PAT_W-1:0]  h_enc_next, h_quad_next, v_enc_next, v_quad_next;
    logic [PW-1:0]     h_pend_next, v_pend_next;

    logic [PW-1:0]     sel_pend;
    logic [SUM_W-1:0]  pend_ext, mag_ext, sum;
    logic [PW-1:0]     sat_pend;
    logic              mp;
    logic              released;

    assign take             = item_valid && (!out_valid_reg || res_ready);
    assign res_valid        = out_valid_reg;
    assign first_port_pins  = first_pins_reg;
    assign second_port_pins = second_pins_reg;

    assign mp       = cfg.mouse_on_second_port;
    assign released = (item.level == LEVEL_ZERO);

    // saturating accumulate, shared by both axes
    assign sel_pend = item.axis_select ? v_pend_reg : h_pend_reg;
    assign pend_ext = {{(SUM_W - PW){sel_pend[PW-1]}}, sel_pend};
    assign mag_ext  = {{(SUM_W - MAG_W){1'b0}}, item.mag};
    assign sum      = item.neg ? (pend_ext - mag_ext) : (pend_ext + mag_ext);

    always_comb
    begin
        if ($signed(sum) > $signed(SAT_MAX))
        begin
            sat_pend = SAT_MAX[PW-1:0];
        end
        else if ($signed(sum) < $signed(SAT_MIN))
        begin
            sat_pend = SAT_MIN[PW-1:0];
        end
        else
        begin
            sat_pend = sum[PW-1:0];
        end
    end

    always_comb
    begin
        pins_next[0] = first_pins_reg;
        pins_next[1] = second_pins_reg;
        h_enc_next   = h_enc_reg;
        h_quad_next  = h_quad_reg;
        v_enc_next   = v_enc_reg;
        v_quad_next  = v_quad_reg;
        h_pend_next  = h_pend_reg;
        v_pend_next  = v_pend_reg;

        case (item.req_type)
            REQ_AXIS:
            begin
                if (item.level != LEVEL_NEG2)
                begin
                    if (item.axis_select)
                    begin
                        pins_next[item.port_select][PIN1] = (item.level != LEVEL_NEG1);
                        pins_next[item.port_select][PIN2] = (item.level != LEVEL_POS1);
                    end
                    else
                    begin
                        pins_next[item.port_select][PIN3] = (item.level != LEVEL_NEG1);
                        pins_next[item.port_select][PIN4] = (item.level != LEVEL_POS1);
                    end
                end
            end
            REQ_FIRE:
            begin
                pins_next[item.port_select][PIN6] = released;
            end
            REQ_MOVE:
            begin
                if (item.axis_select)
                begin
                    v_pend_next = sat_pend;
                end
                else
                begin
                    h_pend_next = sat_pend;
                end
            end
            REQ_LEFT:
            begin
                pins_next[mp][PIN6] = released;
            end
            REQ_RIGHT:
            begin
                pins_next[mp][PIN9] = released;
            end
            REQ_TICK:
            begin
                // positive pending rotates left, negative rotates right
                if (h_pend_reg != '0)
                begin
                    if (!h_pend_reg[PW-1])
                    begin
                        h_enc_next  = {h_enc_reg[PAT_W-1-S:0], h_enc_reg[PAT_W-1:PAT_W-S]};
                        h_quad_next = {h_quad_reg[PAT_W-1-S:0], h_quad_reg[PAT_W-1:PAT_W-S]};
                        h_pend_next = h_pend_reg - PW'(1);
                    end
                    else
                    begin
                        h_enc_next  = {h_enc_reg[S-1:0], h_enc_reg[PAT_W-1:S]};
                        h_quad_next = {h_quad_reg[S-1:0], h_quad_reg[PAT_W-1:S]};
                        h_pend_next = h_pend_reg + PW'(1);
                    end
                    pins_next[mp][PIN2] = h_enc_next[0];
                    if (cfg.mouse_mode)
                    begin
                        pins_next[mp][PIN1] = h_quad_next[0];
                    end
                    else
                    begin
                        pins_next[mp][PIN4] = h_quad_next[0];
                    end
                end
                if (v_pend_reg != '0)
                begin
                    if (!v_pend_reg[PW-1])
                    begin
                        v_enc_next  = {v_enc_reg[PAT_W-1-S:0], v_enc_reg[PAT_W-1:PAT_W-S]};
                        v_quad_next = {v_quad_reg[PAT_W-1-S:0], v_quad_reg[PAT_W-1:PAT_W-S]};
                        v_pend_next = v_pend_reg - PW'(1);
                    end
                    else
                    begin
                        v_enc_next  = {v_enc_reg[S-1:0], v_enc_reg[PAT_W-1:S]};
                        v_quad_next = {v_quad_reg[S-1:0], v_quad_reg[PAT_W-1:S]};
                        v_pend_next = v_pend_reg + PW'(1);
                    end
                    if (cfg.mouse_mode)
                    begin
                        pins_next[mp][PIN3] = v_enc_next[0];
                        pins_next[mp][PIN4] = v_quad_next[0];
                    end
                    else
                    begin
                        pins_next[mp][PIN1] = v_enc_next[0];
                        pins_next[mp][PIN3] = v_quad_next[0];
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg   <= 1'b0;
            first_pins_reg  <= PIN_RESET;
            second_pins_reg <= PIN_RESET;
            h_enc_reg       <= ENC_RESET;
            h_quad_reg      <= QUAD_RESET;
            v_enc_reg       <= ENC_RESET;
            v_quad_reg      <= QUAD_RESET;
            h_pend_reg      <= '0;
            v_pend_reg      <= '0;
        end
        else
        begin
            if (take)
            begin
                out_valid_reg   <= 1'b1;
                first_pins_reg  <= pins_next[0];
                second_pins_reg <= pins_next[1];
                h_enc_reg       <= h_enc_next;
                h_quad_reg      <= h_quad_next;
                v_enc_reg       <= v_enc_next;
                v_quad_reg      <= v_quad_next;
                h_pend_reg      <= h_pend_next;
                v_pend_reg      <= v_pend_next;
            end
            else if (res_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // a result waiting for its beat must not be overwritten
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !res_ready |=> $stable(first_pins_reg) && $stable(second_pins_reg))
        else $error("result pins changed while stalled");

    a_valid_from_item: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(item_valid))
        else $error("result raised without an item");

    a_tick_counts_down: assert property (@(posedge clk) disable iff (!rst_n)
        take && item.req_type == REQ_TICK && !h_pend_reg[PW-1] && h_pend_reg != '0
        |=> h_pend_reg == $past(h_pend_reg) - PW'(1))
        else $error("horizontal pending did not step toward zero");

    a_fixed_pins: assert property (@(posedge clk) disable iff (!rst_n)
        first_pins_reg[7:6] == PIN_RESET[7:6] && first_pins_reg[4] == PIN_RESET[4]
        && second_pins_reg[7:6] == PIN_RESET[7:6] && second_pins_reg[4] == PIN_RESET[4])
        else $error("undriven pin changed");

endmodule

// ===== sv/joystick_mouse_port_emulator.sv =====
// A request is registered in the input stage, then in the result-stage pin registers.
// Throughput: one request per cycle unless res_ready stalls; the gain multiply sits
// in the input stage and the saturating accumulate, pattern rotation and pin update in
// the result stage. The pin registers are the result register; a stalled result stalls
// the input stage. Reset (rst_n low, asynchronous): pins 0x16f on both ports, patterns
// to their seeds, pending counts to zero, mouse on port one, Amiga mapping, gain 333.
module joystick_mouse_port_emulator
    import jmpe_pkg::*;
#(
    parameter int STEP_BITS     = STEP_BITS_DEF,
    parameter int PENDING_WIDTH = PENDING_WIDTH_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_INDEX_W-1:0]   cfg_index,
    input  logic [GAIN_W-1:0]        cfg_data,
    input  logic                     req_valid,
    output logic                     req_ready,
    input  logic [2:0]               req_type,
    input  logic                     port_select,
    input  logic                     axis_select,
    input  logic signed [1:0]        level,
    input  logic signed [DIST_W-1:0] distance,
    output logic                     res_valid,
    input  logic                     res_ready,
    output logic [PINS_W-1:0]        first_port_pins,
    output logic [PINS_W-1:0]        second_port_pins
);

    cfg_t  cfg;
    item_t item;
    logic  item_valid;
    logic  take;

    jmpe_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    jmpe_in_stage u_in (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req_type    (req_type),
        .port_select (port_select),
        .axis_select (axis_select),
        .level       (level),
        .distance    (distance),
        .speed_gain  (cfg.speed_gain),
        .take        (take),
        .item_valid  (item_valid),
        .item        (item)
    );

    jmpe_pin_core #(
        .STEP_BITS     (STEP_BITS),
        .PENDING_WIDTH (PENDING_WIDTH)
    ) u_core (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg              (cfg),
        .item_valid       (item_valid),
        .item             (item),
        .take             (take),
        .res_valid        (res_valid),
        .res_ready        (res_ready),
        .first_port_pins  (first_port_pins),
        .second_port_pins (second_port_pins)
    );

endmodule
